>>> rtl/coefficient_scan_order_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the coefficient scan order core
// Implication checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef COEFFICIENT_SCAN_ORDER_CORE_ASSERT_SVH
`define COEFFICIENT_SCAN_ORDER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk and held off during reset.
`define CSO_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define CSO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CSO_ASSERT_IMPLY(lbl, ante, cons, msg)
`define CSO_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/cso_pkg.sv
// ----------------------------------------------------------------------------
// cso_pkg
// Types, limits and the zigzag table shared by the scan order core.
// ----------------------------------------------------------------------------
package cso_pkg;

  // Block and sampling limits.
  localparam int MAX_BLOCKS       = 1048576;
  localparam int SAMPLE_THRESHOLD = 1024;
  localparam int SKIP_BLOCKS      = 4;

  // Field and counter widths.
  localparam int CFG_W    = 21;
  localparam int BLK_W    = $clog2(MAX_BLOCKS + 1);
  localparam int EFF_W    = (CFG_W > BLK_W) ? CFG_W : BLK_W;
  localparam int PHASE_W  = (SKIP_BLOCKS > 0) ? $clog2(SKIP_BLOCKS + 1) : 1;
  localparam int NPOS     = 64;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 18;
  localparam int TOTAL_W  = COUNT_W + POS_W;
  localparam int EST_W    = 27;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // One input request.
  typedef struct packed {
    logic signed [15:0] coefficient;
    logic               last_coefficient;
  } in_t;

  // One result.
  typedef struct packed {
    logic [POS_W-1:0] scan_rank;
    logic [POS_W-1:0] natural_position;
    logic [EST_W-1:0] nonzero_estimate;
    logic             last_entry;
  } out_t;

  // Access request to the zero count store.
  typedef struct packed {
    logic [POS_W-1:0]   rd_addr;
    logic               wr_en;
    logic [POS_W-1:0]   wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic               clear;
  } mem_req_t;

  // Zigzag index to natural-order index.
  localparam logic [POS_W-1:0] ZZ_TO_NATURAL [NPOS] = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

  function automatic logic [POS_W-1:0] zz_to_natural(input logic [POS_W-1:0] idx);
    return ZZ_TO_NATURAL[idx];
  endfunction

endpackage

>>> rtl/cso_count_mem.sv
// ----------------------------------------------------------------------------
// cso_count_mem
// Zero count store: 64 entries, one registered read and one write per cycle,
// with per-entry valid bits so that a run can be cleared at once.
// ----------------------------------------------------------------------------
module cso_count_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cso_pkg::mem_req_t             req,
  output logic [cso_pkg::COUNT_W-1:0]   rd_key
);
  import cso_pkg::*;

  logic [COUNT_W-1:0] mem [NPOS];
  logic [NPOS-1:0]    valid_r;
  logic [COUNT_W-1:0] rd_data_r;
  logic [POS_W-1:0]   rd_addr_r;

  // Storage array with registered read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
    rd_addr_r <= req.rd_addr;
  end

  // Valid bits: cleared by reset and at the end of each run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clear) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  // An entry never written in this run reads as zero.
  assign rd_key = valid_r[rd_addr_r] ? rd_data_r : '0;

endmodule

>>> rtl/coefficient_scan_order_core.sv
// ----------------------------------------------------------------------------
// coefficient_scan_order_core
// Counts zeros per coefficient position over sampled blocks, then emits the
// 64 zigzag positions ranked by ascending zero count with the nonzero estimate.
// ----------------------------------------------------------------------------
// Counting: one coefficient per cycle while busy is low, no gaps required.
// After the last coefficient: a drain state, then for each rank a scan (64
// count store reads through the shared compare unit) and a tail state that
// registers the result.
// Synchronous reset clears all counters at once; the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "coefficient_scan_order_core_assert.svh"

module coefficient_scan_order_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // Coefficient requests.
  input  logic                        start,
  output logic                        busy,
  input  cso_pkg::in_t                in_data,
  // Ranked results.
  output logic                        out_valid,
  output cso_pkg::out_t               out_data,
  // Block count register.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cso_pkg::CFG_W-1:0]   cfg_data
);
  import cso_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DRAIN, S_SCAN, S_TAIL} state_t;

  state_t             state_r;
  logic [CFG_W-1:0]   block_count_r;
  logic [POS_W-1:0]   pos_r;
  logic [BLK_W-1:0]   blk_r;
  logic [PHASE_W-1:0] phase_r;
  logic [EFF_W-1:0]   nb_last_r;
  logic [TOTAL_W-1:0] total_r;
  logic               inc_d_r;
  logic [POS_W-1:0]   pos_d_r;
  logic [EST_W-1:0]   est_r;
  logic [POS_W-1:0]   rank_r;
  logic [POS_W-1:0]   j_r;
  logic               rd_vld_r;
  logic [POS_W-1:0]   rd_j_r;
  logic [COUNT_W-1:0] best_key_r;
  logic [POS_W-1:0]   best_j_r;
  logic               best_ok_r;
  logic [COUNT_W-1:0] prev_key_r;
  logic [POS_W-1:0]   prev_j_r;
  logic               out_valid_r;
  out_t               out_data_r;

  mem_req_t           req;
  logic [COUNT_W-1:0] mem_key;

  logic               accept;
  logic [EFF_W-1:0]   nb;
  logic               sampled;
  logic               run_done;

  logic [COUNT_W-1:0] key_c;
  logic               above_prev;
  logic               better;
  logic               take;
  logic [COUNT_W-1:0] bk_c;
  logic [POS_W-1:0]   bj_c;

  logic [EST_W-1:0]   est_pos;
  logic [EST_W-1:0]   est_sub;
  logic [EST_W-1:0]   est_calc;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Effective block count and the sampling decision for this coefficient.
  assign nb = (EFF_W'(block_count_r) > EFF_W'(MAX_BLOCKS)) ? EFF_W'(MAX_BLOCKS)
                                                           : EFF_W'(block_count_r);
  assign sampled = (nb >= EFF_W'(SAMPLE_THRESHOLD)) && (phase_r == '0) &&
                   (EFF_W'(blk_r) < nb) && (in_data.coefficient == '0);

  // Count store port: counting reads the current position, the scan walks
  // the zigzag order. The increment is written in the cycle after its read.
  always_comb begin
    req.rd_addr = (state_r == S_SCAN) ? zz_to_natural(j_r) : pos_r;
    req.wr_en   = inc_d_r && (mem_key != COUNT_MAX);
    req.wr_addr = pos_d_r;
    req.wr_data = mem_key + COUNT_W'(1);
    req.clear   = run_done;
  end

  assign run_done = (state_r == S_TAIL) && (rank_r == POS_W'(NPOS - 1));

  cso_count_mem u_count_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .rd_key (mem_key)
  );

  // Shared compare unit: finds the smallest (count, zigzag index) pair that
  // lies above the one chosen for the previous rank. The DC entry counts as zero.
  always_comb begin
    key_c      = (rd_j_r == '0) ? '0 : mem_key;
    above_prev = (rank_r == '0) || (key_c > prev_key_r) ||
                 ((key_c == prev_key_r) && (rd_j_r > prev_j_r));
    better     = !best_ok_r || (key_c < best_key_r);
    take       = rd_vld_r && above_prev && better;
    bk_c       = take ? key_c  : best_key_r;
    bj_c       = take ? rd_j_r : best_j_r;
  end

  // Nonzero estimate, clamped at zero.
  always_comb begin
    est_pos  = (EST_W'(nb_last_r) << POS_W) + EST_W'(SKIP_BLOCKS * NPOS);
    est_sub  = EST_W'(total_r) * EST_W'(SKIP_BLOCKS + 1);
    est_calc = (est_sub > est_pos) ? '0 : est_pos - est_sub;
  end

  // Sequencer, counters and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      block_count_r <= '0;
      pos_r         <= '0;
      blk_r         <= '0;
      phase_r       <= '0;
      total_r       <= '0;
      inc_d_r       <= 1'b0;
      rank_r        <= '0;
      j_r           <= '0;
      rd_vld_r      <= 1'b0;
      best_ok_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        block_count_r <= cfg_data;
      end

      inc_d_r     <= accept && sampled;
      pos_d_r     <= pos_r;
      rd_vld_r    <= (state_r == S_SCAN);
      rd_j_r      <= j_r;
      out_valid_r <= (state_r == S_TAIL);

      if (req.wr_en) begin
        total_r <= total_r + TOTAL_W'(1);
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_data.last_coefficient) begin
              pos_r     <= '0;
              blk_r     <= '0;
              phase_r   <= '0;
              nb_last_r <= nb;
              state_r   <= S_DRAIN;
            end else if (pos_r == POS_W'(NPOS - 1)) begin
              pos_r <= '0;
              if (blk_r < BLK_W'(MAX_BLOCKS)) begin
                blk_r <= blk_r + BLK_W'(1);
              end
              phase_r <= (phase_r >= PHASE_W'(SKIP_BLOCKS)) ? '0 : phase_r + PHASE_W'(1);
            end else begin
              pos_r <= pos_r + POS_W'(1);
            end
          end
        end

        // Let the final increment reach the store before the scan reads it.
        S_DRAIN: begin
          rank_r    <= '0;
          j_r       <= '0;
          best_ok_r <= 1'b0;
          state_r   <= S_SCAN;
        end

        S_SCAN: begin
          if (j_r == '0) begin
            est_r <= est_calc;
          end
          best_key_r <= bk_c;
          best_j_r   <= bj_c;
          best_ok_r  <= best_ok_r || take;
          j_r        <= j_r + POS_W'(1);
          if (j_r == POS_W'(NPOS - 1)) begin
            state_r <= S_TAIL;
          end
        end

        // Last read is folded in here and the rank goes out.
        S_TAIL: begin
          out_data_r.scan_rank          <= rank_r;
          out_data_r.natural_position   <= zz_to_natural(bj_c);
          out_data_r.nonzero_estimate   <= est_r;
          out_data_r.last_entry         <= run_done;
          prev_key_r                    <= bk_c;
          prev_j_r                      <= bj_c;
          best_ok_r                     <= 1'b0;
          rank_r                        <= rank_r + POS_W'(1);
          j_r                           <= '0;
          if (run_done) begin
            total_r <= '0;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_SCAN;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the run sequencing.
  `CSO_ASSERT_IMPLY(a_mid_result_busy, out_valid && !out_data.last_entry, busy, "result before the final rank while not busy")
  `CSO_ASSERT_IMPLY(a_final_result_idle, out_valid && out_data.last_entry, !busy, "still busy after the final rank")
  `CSO_ASSERT_NEXT(a_last_starts_run, accept && in_data.last_coefficient, busy && !out_valid, "last coefficient did not start the ranking")
  `CSO_ASSERT_IMPLY(a_scan_fresh_rank, (state_r == S_SCAN) && (j_r == '0), !rd_vld_r && !best_ok_r, "rank search started with stale compare state")

endmodule
